/* rtl/core/ipk_pkg.sv */
// shared types, constants and the dot length table for the iambic paddle keyer
package ipk_pkg;

    localparam int DOT_W     = 8;
    localparam int DASH_W    = 12;
    localparam int SPEED_W   = 6;
    localparam int WEIGHT_W  = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAPPED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd4;

    // keyer modes
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IAMBIC_A = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IAMBIC_B = 2'd2;

    // speed limits and reset values
    localparam logic [SPEED_W-1:0]  SPEED_MIN     = 6'd5;
    localparam logic [SPEED_W-1:0]  SPEED_MIN_SET = 6'd6;
    localparam logic [SPEED_W-1:0]  SPEED_MAX     = 6'd60;
    localparam logic [SPEED_W-1:0]  SPEED_RESET   = 6'd18;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 8'd50;
    localparam logic [DOT_W-1:0]    DOT_RESET     = 8'd66;
    localparam logic [DASH_W-1:0]   DASH_RESET    = 12'd198;

    // x/50 as (x * DIV50_MUL) >> DIV50_SHIFT, exact for x below 2^18
    localparam int PROD_W      = 18;
    localparam int DIV50_SHIFT = 24;
    localparam int DIV50_W     = 19;
    localparam logic [DIV50_W-1:0] DIV50_MUL = 19'd335545;

    typedef enum logic [3:0] {
        PH_CHECK     = 4'd0,
        PH_PREDOT    = 4'd1,
        PH_PREDASH   = 4'd2,
        PH_SENDDOT   = 4'd3,
        PH_SENDDASH  = 4'd4,
        PH_DOTGAP    = 4'd5,
        PH_DASHGAP   = 4'd6,
        PH_DOTHELD   = 4'd7,
        PH_DASHHELD  = 4'd8,
        PH_LETTERGAP = 4'd9
    } phase_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              swapped;
        logic              spacing;
    } keyer_cfg_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [DASH_W-1:0] dash;
    } lengths_t;

    // 1200 / speed, speed clamped to 5..60
    function automatic logic [DOT_W-1:0] dot_of_speed(input logic [SPEED_W-1:0] speed);
        logic [DOT_W-1:0] d;
        d = 8'd20;
        if (speed <= SPEED_MIN)
        begin
            d = 8'd240;
        end
        else
        begin
            case (speed)
                6'd6:  d = 8'd200;
                6'd7:  d = 8'd171;
                6'd8:  d = 8'd150;
                6'd9:  d = 8'd133;
                6'd10: d = 8'd120;
                6'd11: d = 8'd109;
                6'd12: d = 8'd100;
                6'd13: d = 8'd92;
                6'd14: d = 8'd85;
                6'd15: d = 8'd80;
                6'd16: d = 8'd75;
                6'd17: d = 8'd70;
                6'd18: d = 8'd66;
                6'd19: d = 8'd63;
                6'd20: d = 8'd60;
                6'd21: d = 8'd57;
                6'd22: d = 8'd54;
                6'd23: d = 8'd52;
                6'd24: d = 8'd50;
                6'd25: d = 8'd48;
                6'd26: d = 8'd46;
                6'd27: d = 8'd44;
                6'd28: d = 8'd42;
                6'd29: d = 8'd41;
                6'd30: d = 8'd40;
                6'd31: d = 8'd38;
                6'd32: d = 8'd37;
                6'd33: d = 8'd36;
                6'd34: d = 8'd35;
                6'd35: d = 8'd34;
                6'd36: d = 8'd33;
                6'd37: d = 8'd32;
                6'd38: d = 8'd31;
                6'd39: d = 8'd30;
                6'd40: d = 8'd30;
                6'd41: d = 8'd29;
                6'd42: d = 8'd28;
                6'd43: d = 8'd27;
                6'd44: d = 8'd27;
                6'd45: d = 8'd26;
                6'd46: d = 8'd26;
                6'd47: d = 8'd25;
                6'd48: d = 8'd25;
                6'd49: d = 8'd24;
                6'd50: d = 8'd24;
                6'd51: d = 8'd23;
                6'd52: d = 8'd23;
                6'd53: d = 8'd22;
                6'd54: d = 8'd22;
                6'd55: d = 8'd21;
                6'd56: d = 8'd21;
                6'd57: d = 8'd21;
                default: d = 8'd20;
            endcase
        end
        return d;
    endfunction

endpackage

/* rtl/core/ipk_len_calc.sv */
// configuration registers and the dot and dash length pipeline
module ipk_len_calc
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ipk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipk_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    output ipk_pkg::keyer_cfg_t            cfg,
    output ipk_pkg::lengths_t              lengths,
    output logic                           busy
);
    import ipk_pkg::*;

    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [WEIGHT_W-1:0] weight_reg;
    keyer_cfg_t          cfg_reg;
    logic [DOT_W-1:0]    dot_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DASH_W-1:0]   dash_reg;
    logic [1:0]          busy_reg;
    logic                wr_valid;
    logic [PROD_W+DIV50_W-1:0] quot_full;

    // writes beyond the register list are dropped
    assign wr_valid = cfg_we && (cfg_index <= CFG_SPACING);

    always_comb
    begin
        speed_next = cfg_wdata[SPEED_W-1:0];
        if (speed_next == SPEED_MIN)
        begin
            speed_next = SPEED_MIN_SET;
        end
        else if (speed_next < SPEED_MIN)
        begin
            speed_next = SPEED_MIN;
        end
        else if (speed_next > SPEED_MAX)
        begin
            speed_next = SPEED_MAX;
        end
    end

    assign quot_full = prod_reg * DIV50_MUL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg       <= SPEED_RESET;
            weight_reg      <= WEIGHT_RESET;
            cfg_reg.mode    <= MODE_IAMBIC_B;
            cfg_reg.swapped <= 1'b1;
            cfg_reg.spacing <= 1'b0;
            dot_reg         <= DOT_RESET;
            prod_reg        <= '0;
            dash_reg        <= DASH_RESET;
            busy_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED:   speed_reg       <= speed_next;
                    CFG_WEIGHT:  weight_reg      <= cfg_wdata;
                    CFG_MODE:    cfg_reg.mode    <= cfg_wdata[MODE_W-1:0];
                    CFG_SWAPPED: cfg_reg.swapped <= cfg_wdata[0];
                    CFG_SPACING: cfg_reg.spacing <= cfg_wdata[0];
                    default:     ;
                endcase
            end
            // three steps: table, times 3*weight, divide by 50
            dot_reg  <= dot_of_speed(speed_reg);
            prod_reg <= PROD_W'({2'b00, dot_reg} + {1'b0, dot_reg, 1'b0})
                        * PROD_W'(weight_reg);
            dash_reg <= quot_full[DIV50_SHIFT +: DASH_W];
            if (wr_valid)
            begin
                busy_reg <= 2'd3;
            end
            else if (busy_reg != 2'd0)
            begin
                busy_reg <= busy_reg - 2'd1;
            end
        end
    end

    assign cfg          = cfg_reg;
    assign lengths.dot  = dot_reg;
    assign lengths.dash = dash_reg;
    assign busy         = wr_valid || (busy_reg != 2'd0);

endmodule

/* rtl/core/ipk_fsm.sv */
// keyer state machine: straight key and iambic A/B sequencing, one tick per step
module ipk_fsm
#(
    parameter int COUNT_WIDTH = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                left_closed,
    input  logic                right_closed,
    input  ipk_pkg::keyer_cfg_t cfg,
    input  ipk_pkg::lengths_t   lengths,
    output logic                key_down,
    output logic                transmit_active
);
    import ipk_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic                   dot_pend_reg, dot_pend_next;
    logic                   dash_pend_reg, dash_pend_next;
    logic                   key_reg, key_next;
    logic                   relay_reg, relay_next;

    logic                   dot_in, dash_in;
    logic                   finish;
    logic                   dot_done, dash_done, letter_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CHECK;
            tick_reg      <= '0;
            dot_pend_reg  <= 1'b0;
            dash_pend_reg <= 1'b0;
            key_reg       <= 1'b0;
            relay_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            dot_pend_reg  <= dot_pend_next;
            dash_pend_reg <= dash_pend_next;
            key_reg       <= key_next;
            relay_reg     <= relay_next;
        end
    end

    assign dot_in  = cfg.swapped ? right_closed : left_closed;
    assign dash_in = cfg.swapped ? left_closed : right_closed;

    assign dot_done    = tick_reg >= COUNT_WIDTH'(lengths.dot);
    assign dash_done   = tick_reg >= COUNT_WIDTH'(lengths.dash);
    assign letter_done = tick_reg >= COUNT_WIDTH'({lengths.dot, 1'b0});

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        dot_pend_next  = dot_pend_reg;
        dash_pend_next = dash_pend_reg;
        key_next       = key_reg;
        relay_next     = relay_reg;
        finish         = 1'b0;

        if (cfg.mode == MODE_STRAIGHT)
        begin
            // abandons any iambic run in progress
            phase_next = PH_CHECK;
            tick_next  = '0;
            if (left_closed || right_closed)
            begin
                if (!key_next)
                begin
                    key_next   = 1'b1;
                    relay_next = 1'b1;
                end
            end
            else
            begin
                key_next   = 1'b0;
                relay_next = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CHECK:
                begin
                    if (dot_in)
                    begin
                        phase_next = PH_PREDOT;
                    end
                    else if (dash_in)
                    begin
                        phase_next = PH_PREDASH;
                    end
                    else
                    begin
                        if (key_next)
                        begin
                            key_next   = 1'b0;
                            relay_next = 1'b1;
                        end
                        finish = 1'b1;
                    end
                end
                PH_PREDOT:
                begin
                    dot_pend_next  = 1'b0;
                    dash_pend_next = 1'b0;
                    phase_next     = PH_SENDDOT;
                end
                PH_PREDASH:
                begin
                    dot_pend_next  = 1'b0;
                    dash_pend_next = 1'b0;
                    phase_next     = PH_SENDDASH;
                end
                PH_SENDDOT:
                begin
                    if (!key_next)
                    begin
                        key_next   = 1'b1;
                        relay_next = 1'b1;
                    end
                    if (dot_done)
                    begin
                        tick_next  = '0;
                        key_next   = 1'b0;
                        relay_next = 1'b1;
                        phase_next = PH_DOTGAP;
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (cfg.mode == MODE_IAMBIC_A)
                    begin
                        if (!dot_in && !dash_in)
                        begin
                            dash_pend_next = 1'b0;
                        end
                        else if (dash_in)
                        begin
                            dash_pend_next = 1'b1;
                        end
                    end
                    else if (cfg.mode == MODE_IAMBIC_B && dash_in)
                    begin
                        dash_pend_next = 1'b1;
                    end
                end
                PH_SENDDASH:
                begin
                    if (!key_next)
                    begin
                        key_next   = 1'b1;
                        relay_next = 1'b1;
                    end
                    if (dash_done)
                    begin
                        tick_next  = '0;
                        key_next   = 1'b0;
                        relay_next = 1'b1;
                        phase_next = PH_DASHGAP;
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (cfg.mode == MODE_IAMBIC_A)
                    begin
                        if (!dot_in && !dash_in)
                        begin
                            dot_pend_next = 1'b0;
                        end
                        else if (dot_in)
                        begin
                            dot_pend_next = 1'b1;
                        end
                    end
                    else if (cfg.mode == MODE_IAMBIC_B && dot_in)
                    begin
                        dot_pend_next = 1'b1;
                    end
                end
                PH_DOTGAP:
                begin
                    if (dot_done)
                    begin
                        tick_next  = '0;
                        phase_next = dash_pend_reg ? PH_PREDASH : PH_DOTHELD;
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (dash_in)
                    begin
                        dash_pend_next = 1'b1;
                    end
                end
                PH_DASHGAP:
                begin
                    if (dot_done)
                    begin
                        tick_next  = '0;
                        phase_next = dot_pend_reg ? PH_PREDOT : PH_DASHHELD;
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (dot_in)
                    begin
                        dot_pend_next = 1'b1;
                    end
                end
                PH_DOTHELD, PH_DASHHELD:
                begin
                    // the paddle of the last element wins, then dot before dash
                    priority if (phase_reg == PH_DOTHELD && dot_in)
                    begin
                        phase_next = PH_PREDOT;
                    end
                    else if (phase_reg == PH_DASHHELD && dash_in)
                    begin
                        phase_next = PH_PREDASH;
                    end
                    else if (dot_in)
                    begin
                        phase_next = PH_PREDOT;
                    end
                    else if (dash_in)
                    begin
                        phase_next = PH_PREDASH;
                    end
                    else if (cfg.spacing)
                    begin
                        dot_pend_next  = 1'b0;
                        dash_pend_next = 1'b0;
                        phase_next     = PH_LETTERGAP;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_LETTERGAP:
                begin
                    if (letter_done)
                    begin
                        tick_next = '0;
                        if (dot_pend_reg)
                        begin
                            phase_next = PH_PREDOT;
                        end
                        else if (dash_pend_reg)
                        begin
                            phase_next = PH_PREDASH;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (dot_in)
                    begin
                        dot_pend_next = 1'b1;
                    end
                    if (dash_in)
                    begin
                        dash_pend_next = 1'b1;
                    end
                end
                default:
                begin
                    finish = 1'b1;
                end
            endcase

            if (finish)
            begin
                relay_next = 1'b0;
                phase_next = PH_CHECK;
            end
        end
    end

    assign key_down        = key_next;
    assign transmit_active = relay_next;

endmodule

/* rtl/core/ipk_out_buf.sv */
// two-entry result buffer, its registered full flag keeps result back-pressure off the request path
module ipk_out_buf
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    logic              head_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] head_data_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              pop;

    assign pop = head_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    head_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (!head_valid_reg)
                begin
                    head_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push && !head_valid_reg)
        begin
            head_data_reg <= push_data;
        end
        if (push && head_valid_reg && !pop)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

endmodule

/* rtl/core/iambic_paddle_keyer.sv */
// top level of the iambic paddle keyer: input register, keyer state machine, result buffer
// throughput: one request per cycle while the buffer is not full, one result per request;
// set by the single keyer step, which moves each request from the input register to the buffer
// a configuration write holds off requests while the lengths are rebuilt
// reset: asynchronous, active low; keyer idle with key and relay released, registers at
// speed 18, weight 50, mode B, paddles swapped, no letter spacing
module iambic_paddle_keyer
#(
    parameter int COUNT_WIDTH = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] left_closed, [1] right_closed
    // result side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] key_down, [1] transmit_active
    // configuration writes
    input  logic                          cfg_we,
    input  logic [ipk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipk_pkg::CFG_DAT_W-1:0] cfg_wdata
);
    import ipk_pkg::*;

    localparam int RES_W = 2;

    keyer_cfg_t       cfg;
    lengths_t         lengths;
    logic             busy;

    // input register
    logic             in_valid_reg;
    logic             left_reg;
    logic             right_reg;

    logic             step;
    logic             buf_full;
    logic             key_down;
    logic             transmit_active;
    logic [RES_W-1:0] res_data;
    logic             accept;

    ipk_len_calc u_len_calc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .lengths   (lengths),
        .busy      (busy)
    );

    // take a request whenever the input register empties this cycle or is empty;
    // no requests while the lengths are being rebuilt
    assign step     = in_valid_reg && !buf_full;
    assign s_tready = !busy && (!in_valid_reg || !buf_full);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= s_tdata[0];
            right_reg <= s_tdata[1];
        end
    end

    // one keyer tick per request
    ipk_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .left_closed     (left_reg),
        .right_closed    (right_reg),
        .cfg             (cfg),
        .lengths         (lengths),
        .key_down        (key_down),
        .transmit_active (transmit_active)
    );

    assign res_data = {transmit_active, key_down};

    logic [RES_W-1:0] out_data;

    ipk_out_buf #(
        .DATA_W (RES_W)
    ) u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (res_data),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'b0, out_data};

endmodule
